/* design/rtt_pkg.sv */
// Shared types and codes for the repeating timer table.
`timescale 1ns / 1ps

package rtt_pkg;

   typedef enum logic [2:0] {
      MODE_PULSE  = 3'd0,
      MODE_ADD    = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_RESET  = 3'd3,
      MODE_CLEAR  = 3'd4,
      MODE_LIST   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      KIND_FIRED   = 3'd0,
      KIND_ADDED   = 3'd1,
      KIND_REFUSED = 3'd2,
      KIND_LISTED  = 3'd3,
      KIND_NONE    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   localparam logic [30:0] MIN_INTERVAL_RESET = 31'd50;

   // One timer; due holds start + period so a scan needs a single subtract.
   typedef struct packed {
      logic        in_use;
      logic [31:0] due;
      logic [30:0] period;
      logic [15:0] reps;
   } entry_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] now;
      logic [3:0]  slot;
      logic [30:0] delay;
      logic [15:0] reps;
      logic [30:0] thr;
   } op_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [31:0] left;
      logic [15:0] reps;
   } res_type;

   typedef struct packed {
      logic    valid;
      res_type res;
   } res_msg_type;

endpackage

/* design/rtt_cell.sv */
// One storage cell of the timer ring: loads its neighbor's timer on each shift.
`timescale 1ns / 1ps

module rtt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  rtt_pkg::entry_type   entry_d,
   output rtt_pkg::entry_type   entry_q
);

   logic        in_use_ff;
   logic        in_use_in;
   logic [31:0] due_ff;
   logic [30:0] period_ff;
   logic [15:0] reps_ff;

   assign in_use_in = shift_en ? entry_d.in_use : in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= 1'b0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         due_ff    <= entry_d.due;
         period_ff <= entry_d.period;
         reps_ff   <= entry_d.reps;
      end
   end

   assign entry_q.in_use = in_use_ff;
   assign entry_q.due    = due_ff;
   assign entry_q.period = period_ff;
   assign entry_q.reps   = reps_ff;

endmodule

/* design/rtt_proc.sv */
// Head-of-ring update unit: applies the current operation to one timer.
`timescale 1ns / 1ps

module rtt_proc #(
   parameter int NUM_TIMERS = 16
) (
   input  rtt_pkg::op_type                   op,
   input  logic                              add_ok,
   input  logic                              found,
   input  logic [$clog2(NUM_TIMERS)-1:0]     cnt,
   input  rtt_pkg::entry_type                entry_in,
   output rtt_pkg::entry_type                entry_out,
   output rtt_pkg::res_msg_type              msg,
   output logic                              found_next
);

   localparam int IW = $clog2(NUM_TIMERS);
   localparam int CW = (IW > 4) ? IW : 4;

   logic [31:0] left;
   logic [31:0] due_new;
   logic [31:0] due_add;
   logic        expired;
   logic        match;
   logic        listed;
   logic [15:0] reps_next;

   assign left    = entry_in.due - op.now;
   assign due_new = op.now + {1'b0, entry_in.period};
   assign due_add = op.now + {1'b0, op.delay};
   // now - due is nonnegative exactly when left is zero or a negative value
   // other than the most negative one
   assign expired = (left == 32'd0) || (left[31] && (left[30:0] != 31'd0));
   assign match   = (CW'(op.slot) == CW'(cnt));
   assign listed  = (op.thr == 31'd0) || left[31] || (left[30:0] <= op.thr);
   assign reps_next = (entry_in.reps == 16'd0) ? 16'd0 : entry_in.reps - 16'd1;

   always_comb begin
      entry_out      = entry_in;
      msg.valid      = 1'b0;
      msg.res.kind   = rtt_pkg::KIND_NONE;
      msg.res.slot   = 4'(cnt);
      msg.res.left   = left;
      msg.res.reps   = entry_in.reps;
      found_next     = found;
      unique case (op.mode)
         rtt_pkg::MODE_PULSE: begin
            if (entry_in.in_use && expired) begin
               msg.valid    = 1'b1;
               msg.res.kind = rtt_pkg::KIND_FIRED;
               if (entry_in.reps == 16'd1) begin
                  // last repeat: free the slot
                  entry_out.in_use = 1'b0;
                  msg.res.reps     = 16'd0;
               end else begin
                  entry_out.reps = reps_next;
                  entry_out.due  = due_new;
                  msg.res.reps   = reps_next;
               end
            end
         end
         rtt_pkg::MODE_ADD: begin
            if (!entry_in.in_use && add_ok && !found) begin
               entry_out.in_use = 1'b1;
               entry_out.due    = due_add;
               entry_out.period = op.delay;
               entry_out.reps   = op.reps;
               found_next       = 1'b1;
               msg.valid        = 1'b1;
               msg.res.kind     = rtt_pkg::KIND_ADDED;
               msg.res.left     = {1'b0, op.delay};
               msg.res.reps     = op.reps;
            end
         end
         rtt_pkg::MODE_REMOVE: begin
            if (match) begin
               entry_out.in_use = 1'b0;
            end
         end
         rtt_pkg::MODE_RESET: begin
            if (match && entry_in.in_use) begin
               entry_out.due = due_new;
            end
         end
         rtt_pkg::MODE_CLEAR: begin
            entry_out.in_use = 1'b0;
         end
         rtt_pkg::MODE_LIST: begin
            if (entry_in.in_use && listed) begin
               msg.valid    = 1'b1;
               msg.res.kind = rtt_pkg::KIND_LISTED;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* design/repeating_timer_table_core.sv */
// Top level of the repeating timer table: timer ring, sequencer and result registers.
//
// Usage:
//  - req_* carries one operation per transaction (pulse, add, remove, reset,
//    remove all, list due). A transaction is taken when req_valid is high and
//    req_stall is low.
//  - rsp_* returns the results of each operation in ascending slot order;
//    rsp_last marks the final result of an operation. Every operation gives
//    at least one result.
//  - csr_wr_en / csr_wr_data write min_interval; write only while idle.
// Timing: the timers sit in a ring of NUM_TIMERS cells that rotates once
//  through a single update unit per operation, one slot per cycle unless
//  a stalled result holds the ring. An operation occupies the block from
//  accept through one rotation to the final result; the block takes no new
//  operation until then.
// Stall: while rsp_stall holds a result and another is waiting, the ring
//  stops and resumes once the output register drains.
// Reset: all timers become free and min_interval returns to 50; no clearing
//  pass is needed.
`timescale 1ns / 1ps

module repeating_timer_table_core #(
   parameter int NUM_TIMERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [31:0]        req_now,
   input  logic [3:0]         req_slot,
   input  logic [30:0]        req_delay,
   input  logic [15:0]        req_repeats,
   input  logic [30:0]        req_threshold,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [3:0]         rsp_result_slot,
   output logic signed [31:0] rsp_time_left,
   output logic [15:0]        rsp_repeats_left,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data
);

   localparam int IW = $clog2(NUM_TIMERS);

   rtt_pkg::state_type   state_ff, state_in;
   logic [IW-1:0]        cnt_ff, cnt_in;
   rtt_pkg::op_type      op_ff, op_in;
   logic                 add_ok_ff, add_ok_in;
   logic                 found_ff, found_in;
   logic                 pend_valid_ff, pend_valid_in;
   rtt_pkg::res_type     pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   rtt_pkg::res_type     out_ff, out_in;
   logic                 out_last_ff, out_last_in;
   logic [30:0]          min_interval_ff;

   logic                 shift_en;
   logic                 out_free;
   logic                 need_out;
   logic                 found_next;
   rtt_pkg::res_msg_type msg;
   rtt_pkg::entry_type   head_out;
   rtt_pkg::entry_type   ring_q [NUM_TIMERS];
   rtt_pkg::res_type     final_res;

   // timer ring: cell i takes from cell i+1, the last cell from the update unit
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_ring
      if (i == NUM_TIMERS - 1) begin : g_tail
         rtt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .entry_d  (head_out),
            .entry_q  (ring_q[i])
         );
      end else begin : g_body
         rtt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .entry_d  (ring_q[i+1]),
            .entry_q  (ring_q[i])
         );
      end
   end

   rtt_proc #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_proc (
      .op         (op_ff),
      .add_ok     (add_ok_ff),
      .found      (found_ff),
      .cnt        (cnt_ff),
      .entry_in   (ring_q[0]),
      .entry_out  (head_out),
      .msg        (msg),
      .found_next (found_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= rtt_pkg::MIN_INTERVAL_RESET;
      end else if (csr_wr_en) begin
         min_interval_ff <= csr_wr_data;
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign need_out = msg.valid && pend_valid_ff;

   always_comb begin
      final_res      = '0;
      final_res.kind = (op_ff.mode == rtt_pkg::MODE_ADD) ? rtt_pkg::KIND_REFUSED
                                                         : rtt_pkg::KIND_NONE;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      add_ok_in     = add_ok_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      shift_en      = 1'b0;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in.mode    = rtt_pkg::mode_type'(req_mode);
               op_in.now     = req_now;
               op_in.slot    = req_slot;
               op_in.delay   = req_delay;
               op_in.reps    = req_repeats;
               op_in.thr     = req_threshold;
               add_ok_in     = (req_delay >= min_interval_ff);
               cnt_in        = '0;
               found_in      = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = rtt_pkg::ST_SCAN;
            end
         end
         rtt_pkg::ST_SCAN: begin
            // hold the ring while a result must move out and the output is full
            if (!need_out || out_free) begin
               shift_en = 1'b1;
               cnt_in   = cnt_ff + IW'(1);
               found_in = found_next;
               if (msg.valid) begin
                  pend_in       = msg.res;
                  pend_valid_in = 1'b1;
               end
               if (need_out) begin
                  out_in       = pend_ff;
                  out_last_in  = 1'b0;
                  out_valid_in = 1'b1;
               end
               if (cnt_ff == IW'(NUM_TIMERS - 1)) begin
                  state_in = rtt_pkg::ST_FLUSH;
               end
            end
         end
         rtt_pkg::ST_FLUSH: begin
            if (out_free) begin
               out_in        = pend_valid_ff ? pend_ff : final_res;
               out_last_in   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = rtt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rtt_pkg::ST_IDLE;
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      add_ok_ff   <= add_ok_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign req_stall        = (state_ff != rtt_pkg::ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_result_slot  = out_ff.slot;
   assign rsp_time_left    = out_ff.left;
   assign rsp_repeats_left = out_ff.reps;
   assign rsp_last         = out_last_ff;

endmodule

/* design/rtt_checker.sv */
// Port-level checks for the repeating timer table, bound to the top level.
`timescale 1ns / 1ps

module rtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic [3:0]  rsp_result_slot,
   input logic [31:0] rsp_time_left,
   input logic [15:0] rsp_repeats_left,
   input logic        rsp_last
);

   // a stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its kind, time left and last flag
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_kind) && $stable(rsp_time_left)
                                 && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // the block goes busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken during a scan");

   // an add answers with exactly one result
   a_add_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rtt_pkg::KIND_ADDED || rsp_kind == rtt_pkg::KIND_REFUSED)
      |-> rsp_last)
      else $error("add result not marked last");

   // results without an entry carry zero fields and close the transaction
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rtt_pkg::KIND_NONE || rsp_kind == rtt_pkg::KIND_REFUSED)
      |-> rsp_result_slot == 4'd0 && rsp_time_left == 32'd0
          && rsp_repeats_left == 16'd0 && rsp_last)
      else $error("empty result carries data");

endmodule

bind repeating_timer_table_core rtt_checker u_rtt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_result_slot  (rsp_result_slot),
   .rsp_time_left    (rsp_time_left),
   .rsp_repeats_left (rsp_repeats_left),
   .rsp_last         (rsp_last)
);
